FILE: rtl/hsvrgbw_pkg.sv
// hsvrgbw_pkg: shared types, constants and the fixed-point scale helper
// for the hsv to rgbw converter. no dependencies.
`default_nettype none

package hsvrgbw_pkg;

  localparam int unsigned ChanW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChanW-1:0] ChanMax = 16'hFFFF;
  localparam logic [ChanW-1:0] PosMask = 16'h1FFF;
  localparam logic [ChanW-1:0] OneThird = 16'(65536 / 3);
  localparam logic [ChanW-1:0] Lvl171 = 16'(171 << 8);
  localparam logic [ChanW-1:0] Lvl170 = 16'(170 << 8);
  localparam logic [ChanW-1:0] Lvl85 = 16'(85 << 8);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_YELLOW_MODE = 2'd0,
    CFG_HALVE_GREEN = 2'd1,
    CFG_GREEN_SCALE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEC_RED_ORANGE   = 3'd0,
    SEC_ORANGE_YEL   = 3'd1,
    SEC_YEL_GREEN    = 3'd2,
    SEC_GREEN_AQUA   = 3'd3,
    SEC_AQUA_BLUE    = 3'd4,
    SEC_BLUE_PURPLE  = 3'd5,
    SEC_PURPLE_PINK  = 3'd6,
    SEC_PINK_RED     = 3'd7
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] white;
  } rgbw_t;

  // (a * (b + 1)) >> 16
  function automatic logic [ChanW-1:0] scale16(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    logic [2*ChanW:0] p;
    logic [ChanW:0]   b1;
    b1 = {1'b0, b} + 17'd1;
    p  = {17'b0, a} * {16'b0, b1};
    return p[2*ChanW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hsv16_to_rgbw16_rainbow_unit.sv
// hsv16_to_rgbw16_rainbow_unit: five-stage pipelined rainbow hsv to rgbw converter
// depends on hsvrgbw_pkg
`default_nettype none

// Takes one hsv item per clock whenever start_i is high (busy_o stays low) and
// returns its rgbw result after the five register stages, on result_o for one
// cycle with done_o high. The five register stages are sector ramp and squares,
// hue mapping, green scaling, saturation scaling with the floor, and value
// scaling, each with at most one 16x17 multiply in series. The receiver
// cannot stall: a result must be taken in the cycle done_o is high. Configuration
// writes through cfg_we_i take effect at once and should only be made while no
// item is in flight.
module hsv16_to_rgbw16_rainbow_unit
  import hsvrgbw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire hsv_t               item_i,
  output logic                    busy_o,
  output logic                    done_o,
  output rgbw_t                   result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ChanW-1:0]   cfg_data_i
);

  // configuration registers
  logic             yellow_mode_q;
  logic             halve_green_q;
  logic [ChanW-1:0] green_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yellow_mode_q <= 1'b0;
      halve_green_q <= 1'b0;
      green_scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_YELLOW_MODE: yellow_mode_q <= cfg_data_i[0];
        CFG_HALVE_GREEN: halve_green_q <= cfg_data_i[0];
        CFG_GREEN_SCALE: green_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  logic [5:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:1], accept};
    end
  end

  // ---------------- stage 1: ramp position, value square, floor square
  logic [ChanW-1:0] pos8;
  logic [ChanW-1:0] s1_third_d, s1_v2_d, s1_fl_d;

  assign pos8       = {item_i.hue[12:0], 3'b000};
  assign s1_third_d = scale16(pos8, OneThird);
  assign s1_v2_d    = scale16(item_i.val, item_i.val);
  assign s1_fl_d    = scale16(~item_i.sat, ~item_i.sat);

  logic [ChanW-1:0] s1_third_q, s1_pos8_q, s1_sat_q, s1_v2_q, s1_fl_q;
  logic [2:0]       s1_sector_q;
  logic             s1_vfull_q;

  always_ff @(posedge clk_i) begin
    s1_third_q  <= s1_third_d;
    s1_pos8_q   <= pos8;
    s1_sector_q <= item_i.hue[15:13];
    s1_sat_q    <= item_i.sat;
    s1_v2_q     <= s1_v2_d;
    s1_fl_q     <= s1_fl_d;
    s1_vfull_q  <= (item_i.val == ChanMax);
  end

  // ---------------- stage 2: sector mapping, green halving
  logic [ChanW-1:0] third2;
  logic [ChanW-1:0] s2_r_d, s2_g_d, s2_b_d, g_map;

  assign third2 = {s1_third_q[ChanW-2:0], 1'b0};

  always_comb begin
    s2_r_d = '0;
    g_map  = '0;
    s2_b_d = '0;
    case (sector_e'(s1_sector_q))
      SEC_RED_ORANGE: begin
        s2_r_d = ChanMax - s1_third_q;
        g_map  = s1_third_q;
      end
      SEC_ORANGE_YEL: begin
        if (yellow_mode_q) begin
          s2_r_d = Lvl170 + s1_third_q;
          g_map  = Lvl85 + third2;
        end else begin
          s2_r_d = Lvl171;
          g_map  = Lvl85 + s1_third_q;
        end
      end
      SEC_YEL_GREEN: begin
        if (yellow_mode_q) begin
          s2_r_d = ChanMax - s1_pos8_q;
          g_map  = ChanMax;
        end else begin
          s2_r_d = Lvl171 - third2;
          g_map  = Lvl170 + s1_third_q;
        end
      end
      SEC_GREEN_AQUA: begin
        g_map  = ChanMax - s1_third_q;
        s2_b_d = s1_third_q;
      end
      SEC_AQUA_BLUE: begin
        g_map  = Lvl171 - third2;
        s2_b_d = Lvl85 + third2;
      end
      SEC_BLUE_PURPLE: begin
        s2_r_d = s1_third_q;
        s2_b_d = ChanMax - s1_third_q;
      end
      SEC_PURPLE_PINK: begin
        s2_r_d = Lvl85 + s1_third_q;
        s2_b_d = Lvl171 - s1_third_q;
      end
      SEC_PINK_RED: begin
        s2_r_d = Lvl170 + s1_third_q;
        // wraps near the sector end
        s2_b_d = Lvl85 - s1_third_q;
      end
      default: ;
    endcase
    s2_g_d = halve_green_q ? {1'b0, g_map[ChanW-1:1]} : g_map;
  end

  logic [ChanW-1:0] s2_r_q, s2_g_q, s2_b_q, s2_sat_q, s2_v2_q, s2_fl_q;
  logic             s2_vfull_q;

  always_ff @(posedge clk_i) begin
    s2_r_q     <= s2_r_d;
    s2_g_q     <= s2_g_d;
    s2_b_q     <= s2_b_d;
    s2_sat_q   <= s1_sat_q;
    s2_v2_q    <= s1_v2_q;
    s2_fl_q    <= s1_fl_q;
    s2_vfull_q <= s1_vfull_q;
  end

  // ---------------- stage 3: green scaling
  logic [ChanW-1:0] s3_g_d;
  assign s3_g_d = (green_scale_q != '0) ? scale16(s2_g_q, green_scale_q) : s2_g_q;

  logic [ChanW-1:0] s3_r_q, s3_g_q, s3_b_q, s3_sat_q, s3_v2_q, s3_fl_q;
  logic             s3_vfull_q;

  always_ff @(posedge clk_i) begin
    s3_r_q     <= s2_r_q;
    s3_g_q     <= s3_g_d;
    s3_b_q     <= s2_b_q;
    s3_sat_q   <= s2_sat_q;
    s3_v2_q    <= s2_v2_q;
    s3_fl_q    <= s2_fl_q;
    s3_vfull_q <= s2_vfull_q;
  end

  // ---------------- stage 4: saturation scaling plus floor, full white at zero saturation
  rgbw_t s4_d;

  always_comb begin
    s4_d = '0;
    if (s3_sat_q == ChanMax) begin
      s4_d.red   = s3_r_q;
      s4_d.green = s3_g_q;
      s4_d.blue  = s3_b_q;
    end else if (s3_sat_q == '0) begin
      s4_d.white = ChanMax;
    end else begin
      s4_d.red   = scale16(s3_r_q, s3_sat_q) + s3_fl_q;
      s4_d.green = scale16(s3_g_q, s3_sat_q) + s3_fl_q;
      s4_d.blue  = scale16(s3_b_q, s3_sat_q) + s3_fl_q;
    end
  end

  rgbw_t            s4_q;
  logic [ChanW-1:0] s4_v2_q;
  logic             s4_vfull_q;

  always_ff @(posedge clk_i) begin
    s4_q       <= s4_d;
    s4_v2_q    <= s3_v2_q;
    s4_vfull_q <= s3_vfull_q;
  end

  // ---------------- stage 5: value scaling into the output register
  rgbw_t s5_d;

  always_comb begin
    if (s4_vfull_q) begin
      s5_d = s4_q;
    end else begin
      // a zero square clears every channel through the multiply itself
      s5_d.red   = scale16(s4_q.red, s4_v2_q);
      s5_d.green = scale16(s4_q.green, s4_v2_q);
      s5_d.blue  = scale16(s4_q.blue, s4_v2_q);
      s5_d.white = scale16(s4_q.white, s4_v2_q);
    end
  end

  rgbw_t res_q;

  always_ff @(posedge clk_i) begin
    res_q <= s5_d;
  end

  assign done_o   = vld_q[5];
  assign result_o = res_q;

  // ---------------- checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o)
    else $error("item lost in pipeline");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result without item");

  a_white_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.white != '0) |->
      (result_o.red == '0 && result_o.green == '0 && result_o.blue == '0))
    else $error("white mixed with color");

  a_pure_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && item_i.sat == '0 && item_i.val == ChanMax) |->
      ##5 (result_o.white == ChanMax))
    else $error("zero saturation at full value not full white");

endmodule

`default_nettype wire

FILE: dv/tb_hsv16_to_rgbw16_rainbow_unit.sv
// tb_hsv16_to_rgbw16_rainbow_unit: self-checking bench for the rainbow hsv to rgbw
// converter, with directed corners, random pixels and bursty start traffic.
// depends on hsvrgbw_pkg and hsv16_to_rgbw16_rainbow_unit
`default_nettype none

module tb_hsv16_to_rgbw16_rainbow_unit;
  import hsvrgbw_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned ItemsPerPhase = 55;

  // color model plus the queue of colors still owed by the pipeline
  class pixel_scoreboard;
    bit          yellow_strong;
    bit          green_halved;
    logic [15:0] green_gain;
    rgbw_t       owed_q[$];
    int unsigned errors;

    function new();
      yellow_strong = 1'b0;
      green_halved  = 1'b0;
      green_gain    = '0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_YELLOW_MODE: yellow_strong = data[0];
        CFG_HALVE_GREEN: green_halved = data[0];
        CFG_GREEN_SCALE: green_gain = data;
        default: ;
      endcase
    endfunction

    // fractional multiply: a * (b + 1) / 2^16
    function logic [15:0] frac_mul(logic [15:0] a, logic [15:0] b);
      logic [32:0] prod;
      prod = {17'd0, a} * ({17'd0, b} + 33'd1);
      return prod[31:16];
    endfunction

    function rgbw_t convert(hsv_t px);
      logic [15:0] pos8, third, r, g, b, w, d, fl, v2;
      rgbw_t res;
      pos8  = {px.hue[12:0], 3'b000};
      third = frac_mul(pos8, OneThird);
      w     = '0;
      case (sector_e'(px.hue[15:13]))
        SEC_RED_ORANGE: begin
          r = ChanMax - third; g = third; b = '0;
        end
        SEC_ORANGE_YEL: begin
          if (yellow_strong) begin
            r = Lvl170 + third; g = Lvl85 + (third << 1);
          end else begin
            r = Lvl171; g = Lvl85 + third;
          end
          b = '0;
        end
        SEC_YEL_GREEN: begin
          if (yellow_strong) begin
            r = ChanMax - pos8; g = ChanMax;
          end else begin
            r = Lvl171 - (third << 1); g = Lvl170 + third;
          end
          b = '0;
        end
        SEC_GREEN_AQUA: begin
          r = '0; g = ChanMax - third; b = third;
        end
        SEC_AQUA_BLUE: begin
          r = '0; g = Lvl171 - (third << 1); b = Lvl85 + (third << 1);
        end
        SEC_BLUE_PURPLE: begin
          r = third; g = '0; b = ChanMax - third;
        end
        SEC_PURPLE_PINK: begin
          r = Lvl85 + third; g = '0; b = Lvl171 - third;
        end
        default: begin
          // blue wraps below zero near the end of the pink sector
          r = Lvl170 + third; g = '0; b = Lvl85 - third;
        end
      endcase
      if (green_halved) g = g >> 1;
      if (green_gain != '0) g = frac_mul(g, green_gain);
      if (px.sat == '0) begin
        r = '0; g = '0; b = '0; w = ChanMax;
      end else if (px.sat != ChanMax) begin
        d  = ChanMax - px.sat;
        fl = frac_mul(d, d);
        r  = frac_mul(r, px.sat) + fl;
        g  = frac_mul(g, px.sat) + fl;
        b  = frac_mul(b, px.sat) + fl;
      end
      if (px.val != ChanMax) begin
        v2 = frac_mul(px.val, px.val);
        r  = frac_mul(r, v2);
        g  = frac_mul(g, v2);
        b  = frac_mul(b, v2);
        w  = frac_mul(w, v2);
      end
      res.red   = r;
      res.green = g;
      res.blue  = b;
      res.white = w;
      return res;
    endfunction

    function void note_item(hsv_t px);
      owed_q.push_back(convert(px));
    endfunction

    function void compare_chan(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(rgbw_t got);
      rgbw_t exp_c;
      if (owed_q.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      exp_c = owed_q.pop_front();
      compare_chan("red", exp_c.red, got.red);
      compare_chan("green", exp_c.green, got.green);
      compare_chan("blue", exp_c.blue, got.blue);
      compare_chan("white", exp_c.white, got.white);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  hsv_t               item_i;
  logic               busy_o;
  logic               done_o;
  rgbw_t              result_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ChanW-1:0]   cfg_data_i;

  pixel_scoreboard sb = new();
  int unsigned     burst_left;
  int unsigned     stall_cycles;

  hsv16_to_rgbw16_rainbow_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sampled at the edge, before the block's own updates land
  always @(posedge clk_i) begin : monitor
    bit hit;
    if (rst_ni) begin
      hit = 1'b0;
      if (cfg_we_i) begin
        sb.write_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
        hit = 1'b1;
      end
      if (done_o) begin
        sb.check_result(result_o);
        hit = 1'b1;
      end
      if (start_i && !busy_o) begin
        sb.note_item(item_i);
        hit = 1'b1;
      end
      if (hit) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[hsv16_to_rgbw16_rainbow_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(input hsv_t px);
    start_i <= 1'b1;
    item_i  <= px;
    do @(posedge clk_i); while (busy_o);
  endtask

  // bursts of back-to-back items separated by random gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic push_pixel(input logic [15:0] hue, input logic [15:0] sat,
                            input logic [15:0] val);
    hsv_t px;
    px.hue = hue;
    px.sat = sat;
    px.val = val;
    send_pixel(px);
    pace_sender();
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // upper bits of the one-bit registers carry junk that must be ignored
  task automatic program_regs(input bit ym, input bit hg, input logic [15:0] gs);
    logic [14:0] junk_a, junk_b;
    junk_a = 15'($urandom);
    junk_b = 15'($urandom);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_YELLOW_MODE;
    cfg_data_i <= {junk_a, ym};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HALVE_GREEN;
    cfg_data_i <= {junk_b, hg};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GREEN_SCALE;
    cfg_data_i <= gs;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return ChanMax;
      3: return 16'($urandom_range(0, 300));
      4: return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(input int unsigned n);
    logic [15:0] hue;
    repeat (n) begin
      hue = 16'($urandom);
      // sector edges now and then
      if ($urandom_range(0, 7) == 0) hue[12:0] = $urandom_range(0, 1) ? 13'h1FFF : 13'h0;
      push_pixel(hue, pick_level(), pick_level());
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    item_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_YELLOW_MODE;
    cfg_data_i   = '0;
    burst_left   = 0;
    stall_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both ends of every sector, sector seven blue wraps at the far end
    for (int s = 0; s < 8; s++) begin
      push_pixel({3'(s), 13'h0000}, ChanMax, ChanMax);
      push_pixel({3'(s), 13'h1FFF}, ChanMax, ChanMax);
    end
    // saturation corners: white only, tiny, nearly full, half
    push_pixel(16'h0000, 16'h0000, ChanMax);
    push_pixel(16'h0000, 16'h0001, ChanMax);
    push_pixel(16'h1FFF, 16'hFFFE, ChanMax);
    push_pixel(16'hE123, 16'h8000, ChanMax);
    // value corners: zero square, first nonzero square, near full
    push_pixel(16'h4567, ChanMax, 16'h0000);
    push_pixel(16'h4567, 16'h0000, 16'h00FF);
    push_pixel(16'h4567, 16'h0000, 16'h0100);
    push_pixel(16'hA000, 16'h1234, 16'hFFFE);
    push_pixel(16'h0000, 16'h0000, 16'h0000);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(ItemsPerPhase);

    drain();
    program_regs(1'b1, 1'b0, 16'h0000);
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'b0, 1'b1, 16'h0000);
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'b1, 1'b1, 16'hFFFF);
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'b0, 1'b0, 16'h0001);
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'b1, 1'b0, 16'h8000);
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'b0, 1'b1, 16'($urandom));
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'($urandom), 1'($urandom), 16'($urandom));
    run_random(ItemsPerPhase);
    drain();
    program_regs(1'b0, 1'b0, 16'h0000);
    run_random(ItemsPerPhase);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[hsv16_to_rgbw16_rainbow_unit] OK");
    end else begin
      $display("[hsv16_to_rgbw16_rainbow_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
